// ----- rtl/cosine_similarity_macros.svh -----
// Assertion macros for the cosine similarity controller (cs_ctrl).
`ifndef COSINE_SIMILARITY_MACROS_SVH
`define COSINE_SIMILARITY_MACROS_SVH

// Implication checked on every clock, off during reset.
`define CS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cs_pkg.sv -----
package cs_pkg;

  localparam int ACC_W = 48;
  localparam int OUT_W = 16;
  localparam int ONE_Q14 = 16384;
  // magnitude search: q in 0..16384, 15 iterations
  localparam int Q_W = 15;
  localparam int ITER_N = 15;
  localparam int ITER_W = 4;
  // P up to 2^94, t^2 up to 2^30: compare widths
  localparam int P_W = 94;
  localparam int CMP_W = 128;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [6:0] {
    ST_ACC    = 7'b0000001,
    ST_PREP   = 7'b0000010,
    ST_PMUL   = 7'b0000100,
    ST_TSQ    = 7'b0001000,
    ST_CMUL   = 7'b0010000,
    ST_CMP    = 7'b0100000,
    ST_OUT    = 7'b1000000
  } cs_state_t;

  typedef struct packed {
    logic accum;     // accumulate the input pair
    logic clear;     // clear accumulators after the sum
    logic prep;      // latch final sums, start the search
    logic pmul;      // partial product step of P or xy^2
    logic tsq;       // form t*t for the current midpoint
    logic cmul;      // partial product step of P*t^2
    logic cmp;       // compare and narrow the interval
  } cs_cmd_t;

  typedef struct packed {
    logic pmul_done;
    logic cmul_done;
    logic search_done;
  } cs_sts_t;

endpackage

// ----- rtl/cosine_similarity.sv -----
// Cosine similarity of two streamed vectors.
// Input channel: in_valid/in_ready with in_x_elem, in_y_elem (signed Q3.12)
// and in_row_end. One element pair is accepted per cycle while a row is
// being summed; the three 48-bit sums saturate.
// On the pair with in_row_end set, the row closes and a sequential back end
// finds the Q1.14 result by an up-to-15-step binary search of
// (2q-1)^2 * P <= 2^30 * xy^2, using a 24x24 multiplier for the 4+4 steps
// that form P and xy^2 and a 24x16 one for the 8 steps of each probe.
// From the edge that accepts the row-end pair until out_valid rises, the
// back end runs and in_ready is low.
// Output channel: out_valid/out_ready with out_cosine. The result sits in
// an output register, so the next row may start while it waits; if the
// receiver stalls with a result still held, the next result waits in the
// back end and in_ready stays low.
// Reset (rst_n low, synchronous) clears the sums, the controller and
// out_valid.
module cosine_similarity
  import cs_pkg::*;
#(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ELEM_WIDTH-1:0] in_x_elem,
  input  logic signed [ELEM_WIDTH-1:0] in_y_elem,
  input  logic                         in_row_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_cosine
);

  cs_cmd_t cmd;
  cs_sts_t sts;
  logic    res_load;
  logic signed [OUT_W-1:0] cosine;
  logic signed [OUT_W-1:0] cosine_r;

  cs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_row_end (in_row_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd),
    .res_load   (res_load)
  );

  cs_datapath #(.ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .x_elem (in_x_elem),
    .y_elem (in_y_elem),
    .cmd    (cmd),
    .sts    (sts),
    .cosine (cosine)
  );

  always_ff @(posedge clk) begin
    if (res_load) cosine_r <= cosine;
  end

  assign out_cosine = cosine_r;

endmodule

// ----- rtl/cs_datapath.sv -----
module cs_datapath
  import cs_pkg::*;
#(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [ELEM_WIDTH-1:0] x_elem,
  input  logic signed [ELEM_WIDTH-1:0] y_elem,
  input  cs_cmd_t                      cmd,
  output cs_sts_t                      sts,
  output logic signed [OUT_W-1:0]      cosine
);

  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic signed [ACC_W-1:0] sum_xx_r, sum_yy_r, sum_xy_r;
  logic signed [ACC_W-1:0] sum_xx_nxt, sum_yy_nxt, sum_xy_nxt;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] p
  );
    logic signed [ACC_W+PROD_W:0] s;
    s = (ACC_W+PROD_W+1)'(acc) + (ACC_W+PROD_W+1)'(p);
    if (s > (ACC_W+PROD_W+1)'(ACC_MAX)) return ACC_MAX;
    if (s < (ACC_W+PROD_W+1)'(ACC_MIN)) return ACC_MIN;
    return s[ACC_W-1:0];
  endfunction

  logic signed [PROD_W-1:0] pxx, pyy, pxy;
  assign pxx = x_elem * x_elem;
  assign pyy = y_elem * y_elem;
  assign pxy = x_elem * y_elem;

  always_comb begin
    sum_xx_nxt = sum_xx_r;
    sum_yy_nxt = sum_yy_r;
    sum_xy_nxt = sum_xy_r;
    if (cmd.accum) begin
      sum_xx_nxt = sat_add(sum_xx_r, pxx);
      sum_yy_nxt = sat_add(sum_yy_r, pyy);
      sum_xy_nxt = sat_add(sum_xy_r, pxy);
    end
    if (cmd.clear) begin
      sum_xx_nxt = '0;
      sum_yy_nxt = '0;
      sum_xy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_xx_r <= '0;
      sum_yy_r <= '0;
      sum_xy_r <= '0;
    end else begin
      sum_xx_r <= sum_xx_nxt;
      sum_yy_r <= sum_yy_nxt;
      sum_xy_r <= sum_xy_nxt;
    end
  end

  // Back end operands. Multiplies are split into 24x24 partial products
  // (24x16 for P*t^2), one per cycle, summed into wide accumulators.
  logic [ACC_W-2:0]  a_xx_r, a_yy_r, mag_r;
  logic              neg_r, zero_r;
  logic [P_W-1:0]    p_r;       // max(xx,1)*max(yy,1)
  logic [CMP_W-1:0]  rhs_r;     // 2^30 * xy^2
  logic [CMP_W-1:0]  pacc_r;
  logic [2:0]        pstep_r;   // 0..3 for P, 4..7 for xy^2
  logic [Q_W-1:0]    lo_r, hi_r, q_r;
  logic [2*Q_W+1:0]  tt_r;      // (2q-1)^2
  logic [CMP_W-1:0]  cacc_r;
  logic [2:0]        cstep_r;   // 0..7: 4 P chunks x 2 tt chunks
  logic [ITER_W-1:0] iter_r;

  logic [ACC_W-2:0] xx_f, yy_f, xy_mag;
  assign xx_f = (sum_xx_r < ACC_W'(1)) ? (ACC_W-1)'(1) : sum_xx_r[ACC_W-2:0];
  assign yy_f = (sum_yy_r < ACC_W'(1)) ? (ACC_W-1)'(1) : sum_yy_r[ACC_W-2:0];
  // |ACC_MIN| = 2^47 does not fit 47 bits; take 48-bit magnitude, top bit kept in mag_top_r
  logic [ACC_W-1:0] xy_abs;
  assign xy_abs = sum_xy_r[ACC_W-1] ? ACC_W'(-sum_xy_r) : ACC_W'(sum_xy_r);
  assign xy_mag = xy_abs[ACC_W-2:0];
  logic mag_top_r;

  // partial product select
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [ACC_W-1:0] mag_full;
  assign mag_full = {mag_top_r, mag_r};
  always_comb begin
    if (pstep_r[2]) begin
      pa = pstep_r[1] ? mag_full[47:24] : mag_full[23:0];
      pb = pstep_r[0] ? mag_full[47:24] : mag_full[23:0];
    end else begin
      pa = pstep_r[1] ? {1'b0, a_xx_r[46:24]} : a_xx_r[23:0];
      pb = pstep_r[0] ? {1'b0, a_yy_r[46:24]} : a_yy_r[23:0];
    end
  end
  assign pp = pa * pb;
  logic [6:0] pshift;
  assign pshift = 7'((pstep_r[1] ? 24 : 0) + (pstep_r[0] ? 24 : 0));

  // P*t^2 partial products: P in 4 chunks of 24 (96 bits), tt in 2 of 16
  logic [23:0] ca;
  logic [15:0] cb;
  logic [39:0] cp;
  logic [95:0] p_ext;
  logic [31:0] tt_ext;
  assign p_ext = 96'(p_r);
  assign tt_ext = 32'(tt_r);
  always_comb begin
    case (cstep_r[2:1])
      2'd0: ca = p_ext[23:0];
      2'd1: ca = p_ext[47:24];
      2'd2: ca = p_ext[71:48];
      default: ca = p_ext[95:72];
    endcase
    cb = cstep_r[0] ? tt_ext[31:16] : tt_ext[15:0];
  end
  assign cp = ca * cb;
  logic [6:0] cshift;
  assign cshift = 7'(24 * cstep_r[2:1] + (cstep_r[0] ? 16 : 0));

  logic [Q_W-1:0] q_mid;
  assign q_mid = Q_W'(({1'b0, lo_r} + {1'b0, hi_r} + 16'd1) >> 1);
  // 2q-1 at full square width, so the product keeps every bit
  logic [2*Q_W+1:0] t_mid;
  assign t_mid = {(Q_W+1)'(0), q_mid, 1'b0} - (2*Q_W+2)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstep_r <= '0;
      cstep_r <= '0;
      iter_r  <= '0;
    end else begin
      if (cmd.prep) begin
        a_xx_r    <= xx_f;
        a_yy_r    <= yy_f;
        mag_r     <= xy_mag;
        mag_top_r <= xy_abs[ACC_W-1];
        neg_r     <= sum_xy_r[ACC_W-1];
        zero_r    <= (sum_xy_r == '0);
        pacc_r    <= '0;
        pstep_r   <= '0;
        lo_r      <= '0;
        hi_r      <= Q_W'(ONE_Q14);
        iter_r    <= '0;
      end
      if (cmd.pmul) begin
        pstep_r <= pstep_r + 3'd1;
        if (pstep_r == 3'd3) begin
          p_r    <= P_W'(pacc_r + (CMP_W'(pp) << pshift));
          pacc_r <= '0;
        end else if (pstep_r == 3'd7) begin
          rhs_r  <= (pacc_r + (CMP_W'(pp) << pshift)) << 30;
        end else begin
          pacc_r <= pacc_r + (CMP_W'(pp) << pshift);
        end
      end
      if (cmd.tsq) begin
        q_r     <= q_mid;
        tt_r    <= t_mid * t_mid;
        cacc_r  <= '0;
        cstep_r <= '0;
      end
      if (cmd.cmul) begin
        cacc_r  <= cacc_r + (CMP_W'(cp) << cshift);
        cstep_r <= cstep_r + 3'd1;
      end
      if (cmd.cmp) begin
        if (cacc_r <= rhs_r) lo_r <= q_r;
        else hi_r <= q_r - Q_W'(1);
        iter_r <= iter_r + ITER_W'(1);
      end
    end
  end

  assign sts.pmul_done   = (pstep_r == 3'd7);
  assign sts.cmul_done   = (cstep_r == 3'd7);
  assign sts.search_done = (lo_r >= hi_r) || (iter_r == ITER_W'(ITER_N));

  logic [OUT_W-1:0] mag_out;
  assign mag_out = zero_r ? '0 : OUT_W'(lo_r);
  assign cosine  = neg_r ? OUT_W'(-mag_out) : mag_out;

endmodule

// ----- rtl/cs_ctrl.sv -----
`include "cosine_similarity_macros.svh"

module cs_ctrl
  import cs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_row_end,
  output logic    out_valid,
  input  logic    out_ready,
  input  cs_sts_t sts,
  output cs_cmd_t cmd,
  output logic    res_load
);

  cs_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      in_fire;

  // Results wait in the output register; a new row may start meanwhile.
  assign in_ready = (state_r == ST_ACC);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    res_load = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_ACC: begin
        if (in_fire) begin
          cmd.accum = 1'b1;
          if (in_row_end) state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        cmd.clear = 1'b1;
        state_nxt = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.pmul = 1'b1;
        if (sts.pmul_done) state_nxt = ST_TSQ;
      end
      ST_TSQ: begin
        if (sts.search_done) state_nxt = ST_OUT;
        else begin
          cmd.tsq = 1'b1;
          state_nxt = ST_CMUL;
        end
      end
      ST_CMUL: begin
        cmd.cmul = 1'b1;
        if (sts.cmul_done) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        state_nxt = ST_TSQ;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          res_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CS_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `CS_ASSERT_NEXT(a_row_end, clk, rst_n, in_fire && in_row_end, state_r == ST_PREP,
                  "row end did not start back end")
  `CS_ASSERT_NEXT(a_load, clk, rst_n, res_load, out_valid_r, "result load lost")
  `CS_ASSERT_IMP(a_noload, clk, rst_n, res_load, state_r == ST_OUT, "load outside output state")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cs_pkg::*;

  localparam int EW = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [EW-1:0] in_x_elem;
  logic signed [EW-1:0] in_y_elem;
  logic in_row_end;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] out_cosine;

  cosine_similarity #(.ELEM_WIDTH(EW)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_elem(in_x_elem), .in_y_elem(in_y_elem), .in_row_end(in_row_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_cosine(out_cosine)
  );

  longint acc_xx, acc_yy, acc_xy;
  logic signed [OUT_W-1:0] cosine_q[$];
  int errors;
  int idle_cycles;
  int burst_left;
  bit stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sum_sat(longint acc, longint p);
    longint s;
    s = acc + p;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  // largest q with (2q-1)^2 * P <= 2^30 * xy^2, searched in 256-bit math
  function automatic logic signed [OUT_W-1:0] row_cosine(longint xx, longint yy, longint xy);
    logic [255:0] p, rhs, t;
    logic [63:0] mag;
    int lo, hi, q;
    if (xy == 0) return '0;
    mag = (xy < 0) ? -xy : xy;
    p = 256'(xx < 1 ? 1 : xx) * 256'(yy < 1 ? 1 : yy);
    rhs = (256'(mag) * 256'(mag)) << 30;
    lo = 0;
    hi = ONE_Q14;
    while (lo < hi) begin
      q = (lo + hi + 1) / 2;
      t = 256'(2 * q - 1);
      if (p * t * t <= rhs) lo = q;
      else hi = q - 1;
    end
    return (xy < 0) ? OUT_W'(-lo) : OUT_W'(lo);
  endfunction

  // drives settle at the falling edge; back-to-back calls drop and raise
  // in_valid in the same step, so the drives are blocking
  task automatic send_pair(logic signed [EW-1:0] x, logic signed [EW-1:0] y, bit last);
    longint xv, yv;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid = 1'b1;
    in_x_elem = x;
    in_y_elem = y;
    in_row_end = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    xv = x;
    yv = y;
    acc_xx = sum_sat(acc_xx, xv * xv);
    acc_yy = sum_sat(acc_yy, yv * yv);
    acc_xy = sum_sat(acc_xy, xv * yv);
    if (last) begin
      cosine_q.push_back(row_cosine(acc_xx, acc_yy, acc_xy));
      acc_xx = 0;
      acc_yy = 0;
      acc_xy = 0;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [EW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic send_row(int len);
    for (int i = 0; i < len; i++)
      send_pair(rand_elem(), rand_elem(), i == len - 1);
  endtask

  task automatic test_directed();
    send_pair(0, 0, 1);                    // zero vectors
    send_pair(16'sh7fff, 16'sh7fff, 1);
    send_pair(16'sh8000, 16'sh7fff, 1);
    send_pair(16'sh8000, 16'sh8000, 1);
    send_pair(16'sh1000, 0, 1);            // one zero vector
    send_pair(16'sh1000, 16'sh2000, 0);    // orthogonal pair
    send_pair(16'sh2000, -16'sh1000, 1);
    send_pair(16'sh0001, 16'shffff, 0);
    send_pair(16'sh5555, 16'shaaaa, 1);
    send_pair(16'sh0001, 16'sh0003, 1);
  endtask

  // rows of full-scale pairs, one of mixed signs and one exactly anti-parallel
  task automatic test_extreme_rows();
    for (int i = 0; i < 20; i++)
      send_pair(16'sh8000, (i % 3 == 0) ? 16'sh8000 : 16'sh7fff, i == 19);
    for (int i = 0; i < 20; i++)
      send_pair(16'sh8000, 16'sh7fff, i == 19);
  endtask

  task automatic test_random_rows();
    int sent;
    sent = 0;
    while (sent < 1480) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      send_row(len);
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cosine_q.size() == 0) begin
        $display("%0t: unexpected result, actual cosine %0d", $time, out_cosine);
        errors++;
      end else begin
        if (out_cosine !== cosine_q[0]) begin
          $display("%0t: cosine mismatch, expected %0d actual %0d",
                   $time, cosine_q[0], out_cosine);
          errors++;
        end
        void'(cosine_q.pop_front());
      end
    end
  end

  // receiver stall pattern: alternating runs of stall and flow
  always @(negedge clk) begin
    if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
    out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    stall_on = 1'b0;
    acc_xx = 0;
    acc_yy = 0;
    acc_xy = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_elem = '0;
    in_y_elem = '0;
    in_row_end = 1'b0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_rows();
    test_extreme_rows();
    while (cosine_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cs_pkg.sv
rtl/cs_datapath.sv
rtl/cs_ctrl.sv
rtl/cosine_similarity.sv
verif/testbench.sv
